>>> src/aes_pkg.sv
// Package with AES-128 types, constants and round functions.
`default_nettype none
package aes_pkg;
   localparam int unsigned BLOCK_W  = 128;
   localparam int unsigned HALF_W   = 64;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned ROUNDS   = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 1'b1;

   localparam logic [7:0] GF_POLY = 8'h1b;

   typedef logic [7:0] byte_type;
   typedef logic [BLOCK_W-1:0] block_type;

   function automatic byte_type sbox(input byte_type a);
      byte_type r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r=8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xtime(input byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   // Byte i of the block sits at bits [127-8i -: 8].
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[BLOCK_W-1-8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type b);
      block_type r;
      for (int i = 0; i < 16; i++) begin
         r[BLOCK_W-1-8*i -: 8] = sbox(get_byte(b, (i + 4*(i%4)) % 16));
      end
      return r;
   endfunction

   function automatic block_type mix_cols(input block_type b);
      block_type r;
      byte_type a0, a1, a2, a3, x;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(b, 4*c);
         a1 = get_byte(b, 4*c+1);
         a2 = get_byte(b, 4*c+2);
         a3 = get_byte(b, 4*c+3);
         x = a0 ^ a1 ^ a2 ^ a3;
         r[BLOCK_W-1-32*c -: 8]  = a0 ^ x ^ xtime(a0 ^ a1);
         r[BLOCK_W-9-32*c -: 8]  = a1 ^ x ^ xtime(a1 ^ a2);
         r[BLOCK_W-17-32*c -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
         r[BLOCK_W-25-32*c -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
      end
      return r;
   endfunction

   // One key-schedule step: next round key from the previous one.
   function automatic block_type next_key(input block_type k, input byte_type rc);
      logic [31:0] t, w0, w1, w2, w3;
      t = k[31:0];
      t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
          ^ {rc, 24'h0};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic byte_type rcon(input int r);
      byte_type c;
      c = 8'h01;
      for (int i = 1; i < 10; i++) begin
         if (i < r) c = xtime(c);
      end
      return c;
   endfunction
endpackage
`default_nettype wire

>>> src/aes_stream_if.sv
// Valid/ready stream interface carrying a 128-bit block as two halves.
`default_nettype none
interface aes_stream_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_high;
   logic [63:0] data_low;
   modport source (output valid, output data_high, output data_low, input ready);
   modport sink (input valid, input data_high, input data_low, output ready);
endinterface
`default_nettype wire

>>> src/aes128_block_encrypt_core.sv
// Top level of the fully pipelined AES-128 encryption core.
//
//   channel | direction | handshake            | payload
//   req     | in        | req.valid/req.ready  | data_high = plain_high, data_low = plain_low
//   rsp     | out       | rsp.valid/rsp.ready  | data_high = cipher_high, data_low = cipher_low
//   csr     | in        | csr_we               | csr_index, csr_wdata (key_high, key_low)
//
// One request is accepted per cycle unless the output stalls or the keys are being
// expanded. A stage does the initial AddRoundKey, then one register stage per cipher round.
// The round keys are expanded after a key write, one round of the key schedule
// per cycle. Keys are to be written only while the core is idle; the core does
// not enforce this, but holds req.ready low until the expansion is done.
// Reset is synchronous and clears the valid bits and the key, then
// expands the all-zero key. A stall at the output freezes every stage
// that cannot move, so nothing is lost or repeated.
`default_nettype none
module aes128_block_encrypt_core (
   input  wire logic        clock,
   input  wire logic        reset,
   aes_stream_if.sink       req,
   aes_stream_if.source     rsp,
   input  wire logic        csr_we,
   input  wire logic [aes_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0] csr_wdata
);
   localparam int unsigned NSTG = aes_pkg::ROUNDS + 1;

   logic [63:0]               key_high_ff, key_low_ff;
   aes_pkg::block_type        rk_ff [aes_pkg::ROUNDS+1];
   aes_pkg::block_type        rk_in [aes_pkg::ROUNDS+1];
   logic [3:0]                exp_cnt_ff;
   logic                      exp_busy_ff;

   aes_pkg::block_type        data_ff [NSTG];
   logic                      vld_ff  [NSTG];
   logic                      adv     [NSTG];

   // Key registers and a ten-step schedule, one round key per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         exp_busy_ff <= 1'b1;
         exp_cnt_ff  <= 4'd0;
         rk_ff[0]    <= '0;
      end else if (csr_we) begin
         if (csr_index == aes_pkg::CSR_KEY_HIGH) begin
            key_high_ff <= csr_wdata;
            rk_ff[0]    <= {csr_wdata, key_low_ff};
         end else begin
            key_low_ff <= csr_wdata;
            rk_ff[0]   <= {key_high_ff, csr_wdata};
         end
         exp_busy_ff <= 1'b1;
         exp_cnt_ff  <= 4'd0;
      end else if (exp_busy_ff) begin
         for (int r = 1; r <= aes_pkg::ROUNDS; r++) rk_ff[r] <= rk_in[r];
         if (exp_cnt_ff == 4'(aes_pkg::ROUNDS - 1)) exp_busy_ff <= 1'b0;
         exp_cnt_ff <= exp_cnt_ff + 4'd1;
      end
   end

   always_comb begin
      for (int r = 0; r <= aes_pkg::ROUNDS; r++) rk_in[r] = rk_ff[r];
      for (int r = 1; r <= aes_pkg::ROUNDS; r++) begin
         if (exp_cnt_ff == 4'(r - 1))
            rk_in[r] = aes_pkg::next_key(rk_ff[r-1], aes_pkg::rcon(r));
      end
   end

   // Pipeline: stage s moves when it is empty or the next one moves.
   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp.ready;
      for (int s = NSTG - 2; s >= 0; s--) adv[s] = !vld_ff[s] || adv[s+1];
   end

   assign req.ready = adv[0] && !exp_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) vld_ff[s] <= 1'b0;
      end else begin
         if (adv[0]) vld_ff[0] <= req.valid && !exp_busy_ff;
         for (int s = 1; s < NSTG; s++) begin
            if (adv[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) data_ff[0] <= {req.data_high, req.data_low} ^ rk_ff[0];
      for (int s = 1; s < NSTG - 1; s++) begin
         if (adv[s])
            data_ff[s] <= aes_pkg::mix_cols(aes_pkg::sub_shift(data_ff[s-1])) ^ rk_ff[s];
      end
      if (adv[NSTG-1])
         data_ff[NSTG-1] <= aes_pkg::sub_shift(data_ff[NSTG-2]) ^ rk_ff[aes_pkg::ROUNDS];
   end

   assign rsp.valid     = vld_ff[NSTG-1];
   assign rsp.data_high = data_ff[NSTG-1][127:64];
   assign rsp.data_low  = data_ff[NSTG-1][63:0];

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      exp_busy_ff |-> !req.ready) else $error("request accepted during key expansion");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("stalled response dropped");
   a_exp_len: assert property (@(posedge clock) disable iff (reset)
      (exp_busy_ff && exp_cnt_ff == 4'd0 && !csr_we) |-> ##9 exp_busy_ff)
      else $error("key expansion ended early");
`endif
endmodule
`default_nettype wire
